[rtl/gou_pkg.sv]
// Shared types, constants and helpers for the gradient optimizer update block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package gou_pkg;

   localparam int REG_BITS  = 24;
   localparam int DIV_STEPS = 32;

   localparam logic [24:0] REG_ONE  = 25'h1000000;
   localparam logic [23:0] LR_LIMIT = 24'd1677721;

   localparam logic [23:0] LR_RESET  = 24'd167772;
   localparam logic [23:0] B1_RESET  = 24'd15099494;
   localparam logic [23:0] B2_RESET  = 24'd16760439;
   localparam logic [23:0] EPS_RESET = 24'd1;

   localparam logic [2:0] MODE_SGD      = 3'd0;
   localparam logic [2:0] MODE_MOMENTUM = 3'd1;
   localparam logic [2:0] MODE_ADAGRAD  = 3'd2;
   localparam logic [2:0] MODE_RMSPROP  = 3'd3;
   localparam logic [2:0] MODE_ADAM     = 3'd4;

   localparam logic [2:0] CSR_MODE = 3'd0;
   localparam logic [2:0] CSR_LR   = 3'd1;
   localparam logic [2:0] CSR_B1   = 3'd2;
   localparam logic [2:0] CSR_B2   = 3'd3;
   localparam logic [2:0] CSR_EPS  = 3'd4;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_LR_BAD = 2'd1;
   localparam logic [1:0] STAT_SAT    = 2'd2;

   localparam logic signed [31:0] DATA_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] DATA_MIN = 32'sh80000000;

   typedef struct packed {
      logic signed [31:0] weight_in;
      logic signed [31:0] gradient;
      logic [9:0]         slot;
      logic               is_bias;
      logic               begins_call;
   } req_type;

   typedef struct packed {
      logic signed [31:0] weight_out;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [5:0] {
      ST_CLEAR, ST_IDLE, ST_FETCH, ST_PASS, ST_MUL_GLR, ST_MUL_P1, ST_POW1, ST_MUL_P2,
      ST_POW2, ST_MUL_GG, ST_GSQ, ST_VADD, ST_MUL_MB1, ST_MUL_GB1, ST_DEC_M, ST_MUL_MLR,
      ST_MUL_VB2, ST_MUL_TB2, ST_DEC_V, ST_DIV_M, ST_DM_RUN, ST_DM_END, ST_SET_N,
      ST_DIV_V, ST_DV_RUN, ST_DV_END, ST_SQRT_V, ST_SQRT_Q, ST_SQ_RUN, ST_DIV_R,
      ST_DR_RUN, ST_DR_END, ST_MUL_QLR, ST_RES, ST_DONE
   } ctrl_state_type;

   typedef enum logic [5:0] {
      OP_NONE, OP_CLEAR, OP_LOAD, OP_FETCH, OP_MUL_GLR, OP_MUL_MB1, OP_MUL_GB1,
      OP_MUL_MLR, OP_MUL_QLR, OP_MUL_GG, OP_MUL_VB2, OP_MUL_TB2, OP_MUL_P1, OP_MUL_P2,
      OP_POW1, OP_POW2, OP_GSQ, OP_VADD, OP_DEC_M, OP_DEC_V, OP_DIV_M, OP_DIV_V,
      OP_DIV_R, OP_DIV_STEP, OP_DIV_END, OP_SET_N, OP_SQRT_V, OP_SQRT_Q, OP_SQRT_STEP,
      OP_RES, OP_PASS, OP_STORE, OP_EMIT
   } dp_op_type;

   typedef struct packed {
      logic lr_bad;
      logic starts;
      logic clear_done;
      logic div_done;
      logic sqrt_done;
      logic out_free;
   } dp_stat_type;

   // {saturated flag, clamped value}
   function automatic logic [32:0] sat32(input logic signed [71:0] x);
      if (x > 72'sd2147483647) begin
         return {1'b1, DATA_MAX};
      end else if (x < -72'sd2147483648) begin
         return {1'b1, DATA_MIN};
      end
      return {1'b0, x[31:0]};
   endfunction

endpackage

[rtl/gradient_optimizer_update.sv]
// Gradient optimizer update: one updated weight per input item (SGD, momentum,
// Adagrad, RMSprop, Adam). Instantiates gou_ctrl and gou_dp; uses gou_pkg.
//
// Usage:
//  - req channel (valid/ready) carries weight, gradient, slot, bank flag and
//    call-start flag; rsp channel returns the updated weight and a status.
//  - csr channel writes mode, learning rate, betas and epsilon; write it only
//    while no item is in flight. csr_ready is always high.
//  - One item at a time. Each divide runs through the one-bit-per-cycle
//    divider, and the square root works through P = (33+FRAC_BITS)/2 steps.
//  - The next item is taken as soon as the result sits in the output
//    register; a stalled rsp side blocks only the final transfer of the
//    following item.
//  - After reset the moment stores are zeroed one word per cycle,
//    max(WEIGHT_SLOTS, BIAS_SLOTS) words, with req_ready low.
`timescale 1ns / 1ps
module gradient_optimizer_update import gou_pkg::*; #(
   parameter int WEIGHT_SLOTS = 1024,
   parameter int BIAS_SLOTS   = 256,
   parameter int FRAC_BITS    = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   logic [2:0]  mode_ff, mode_in;
   logic [23:0] lr_ff, lr_in, b1_ff, b1_in, b2_ff, b2_in, eps_ff, eps_in;
   dp_stat_type stat;
   dp_op_type   op;

   assign csr_ready = 1'b1;

   always_comb begin
      mode_in = mode_ff;
      lr_in   = lr_ff;
      b1_in   = b1_ff;
      b2_in   = b2_ff;
      eps_in  = eps_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE: mode_in = csr_data[2:0];
            CSR_LR:   lr_in   = csr_data;
            CSR_B1:   b1_in   = csr_data;
            CSR_B2:   b2_in   = csr_data;
            CSR_EPS:  eps_in  = csr_data;
            default:  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SGD;
         lr_ff   <= LR_RESET;
         b1_ff   <= B1_RESET;
         b2_ff   <= B2_RESET;
         eps_ff  <= EPS_RESET;
      end else begin
         mode_ff <= mode_in;
         lr_ff   <= lr_in;
         b1_ff   <= b1_in;
         b2_ff   <= b2_in;
         eps_ff  <= eps_in;
      end
   end

   gou_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .stat      (stat),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .op        (op)
   );

   gou_dp #(
      .WEIGHT_SLOTS (WEIGHT_SLOTS),
      .BIAS_SLOTS   (BIAS_SLOTS),
      .FRAC_BITS    (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .lr        (lr_ff),
      .b1        (b1_ff),
      .b2        (b2_ff),
      .eps       (eps_ff),
      .req_data  (req_data),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // result register only loaded when it is empty or draining
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (op == OP_STORE || op == OP_EMIT) |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over a pending transfer");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(op == OP_STORE || op == OP_EMIT))
      else $error("rsp_valid rose without a result load");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item accepted while busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STAT_OK || rsp_data.status == STAT_LR_BAD
                     || rsp_data.status == STAT_SAT))
      else $error("undefined status code");

endmodule

[rtl/gou_ctrl.sv]
// Sequencer for the optimizer update: walks each item through the datapath ops.
// Depends on gou_pkg.
`timescale 1ns / 1ps
module gou_ctrl import gou_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [2:0]  mode,
   input  dp_stat_type stat,
   input  logic        req_valid,
   output logic        req_ready,
   output dp_op_type   op
);

   ctrl_state_type state_ff, state_in;
   logic           write_back;

   assign write_back = !stat.lr_bad && (mode <= MODE_ADAM);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:   if (stat.clear_done) state_in = ST_IDLE;
         ST_IDLE:    if (req_valid) state_in = ST_FETCH;
         ST_FETCH: begin
            if (stat.lr_bad || mode > MODE_ADAM) begin
               state_in = ST_PASS;
            end else if (mode == MODE_SGD) begin
               state_in = ST_MUL_GLR;
            end else if (mode == MODE_MOMENTUM) begin
               state_in = ST_MUL_MB1;
            end else if (mode == MODE_ADAM && stat.starts) begin
               state_in = ST_MUL_P1;
            end else begin
               state_in = ST_MUL_GG;
            end
         end
         ST_PASS:    state_in = ST_DONE;
         ST_MUL_GLR: state_in = ST_RES;
         ST_MUL_P1:  state_in = ST_POW1;
         ST_POW1:    state_in = ST_MUL_P2;
         ST_MUL_P2:  state_in = ST_POW2;
         ST_POW2:    state_in = ST_MUL_GG;
         ST_MUL_GG:  state_in = ST_GSQ;
         ST_GSQ: begin
            if (mode == MODE_ADAGRAD) begin
               state_in = ST_VADD;
            end else if (mode == MODE_RMSPROP) begin
               state_in = ST_MUL_VB2;
            end else begin
               state_in = ST_MUL_MB1;
            end
         end
         ST_VADD:    state_in = ST_SQRT_V;
         ST_MUL_MB1: state_in = ST_MUL_GB1;
         ST_MUL_GB1: state_in = ST_DEC_M;
         ST_DEC_M:   state_in = (mode == MODE_MOMENTUM) ? ST_MUL_MLR : ST_MUL_VB2;
         ST_MUL_MLR: state_in = ST_RES;
         ST_MUL_VB2: state_in = ST_MUL_TB2;
         ST_MUL_TB2: state_in = ST_DEC_V;
         ST_DEC_V:   state_in = (mode == MODE_ADAM) ? ST_DIV_M : ST_SQRT_V;
         ST_DIV_M:   state_in = ST_DM_RUN;
         ST_DM_RUN:  if (stat.div_done) state_in = ST_DM_END;
         ST_DM_END:  state_in = ST_SET_N;
         ST_SET_N:   state_in = ST_DIV_V;
         ST_DIV_V:   state_in = ST_DV_RUN;
         ST_DV_RUN:  if (stat.div_done) state_in = ST_DV_END;
         ST_DV_END:  state_in = ST_SQRT_Q;
         ST_SQRT_V:  state_in = ST_SQ_RUN;
         ST_SQRT_Q:  state_in = ST_SQ_RUN;
         ST_SQ_RUN:  if (stat.sqrt_done) state_in = ST_DIV_R;
         ST_DIV_R:   state_in = ST_DR_RUN;
         ST_DR_RUN:  if (stat.div_done) state_in = ST_DR_END;
         ST_DR_END:  state_in = ST_MUL_QLR;
         ST_MUL_QLR: state_in = ST_RES;
         ST_RES:     state_in = ST_DONE;
         ST_DONE:    if (stat.out_free) state_in = ST_IDLE;
         default:    state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      op        = OP_NONE;
      unique case (state_ff)
         ST_CLEAR:   op = OP_CLEAR;
         ST_IDLE: begin
            req_ready = 1'b1;
            op        = req_valid ? OP_LOAD : OP_NONE;
         end
         ST_FETCH:   op = OP_FETCH;
         ST_PASS:    op = OP_PASS;
         ST_MUL_GLR: op = OP_MUL_GLR;
         ST_MUL_P1:  op = OP_MUL_P1;
         ST_POW1:    op = OP_POW1;
         ST_MUL_P2:  op = OP_MUL_P2;
         ST_POW2:    op = OP_POW2;
         ST_MUL_GG:  op = OP_MUL_GG;
         ST_GSQ:     op = OP_GSQ;
         ST_VADD:    op = OP_VADD;
         ST_MUL_MB1: op = OP_MUL_MB1;
         ST_MUL_GB1: op = OP_MUL_GB1;
         ST_DEC_M:   op = OP_DEC_M;
         ST_MUL_MLR: op = OP_MUL_MLR;
         ST_MUL_VB2: op = OP_MUL_VB2;
         ST_MUL_TB2: op = OP_MUL_TB2;
         ST_DEC_V:   op = OP_DEC_V;
         ST_DIV_M:   op = OP_DIV_M;
         ST_DIV_V:   op = OP_DIV_V;
         ST_DIV_R:   op = OP_DIV_R;
         ST_DM_RUN, ST_DV_RUN, ST_DR_RUN: op = OP_DIV_STEP;
         ST_DM_END, ST_DV_END, ST_DR_END: op = OP_DIV_END;
         ST_SET_N:   op = OP_SET_N;
         ST_SQRT_V:  op = OP_SQRT_V;
         ST_SQRT_Q:  op = OP_SQRT_Q;
         ST_SQ_RUN:  op = OP_SQRT_STEP;
         ST_MUL_QLR: op = OP_MUL_QLR;
         ST_RES:     op = OP_RES;
         ST_DONE: begin
            if (stat.out_free) op = write_back ? OP_STORE : OP_EMIT;
         end
         default:    op = OP_NONE;
      endcase
   end

endmodule

[rtl/gou_dp.sv]
// Datapath for the optimizer update: moment stores, shared multiplier,
// bit-serial divider, digit-serial square root and result register. Uses gou_pkg.
`timescale 1ns / 1ps
module gou_dp import gou_pkg::*; #(
   parameter int WEIGHT_SLOTS = 1024,
   parameter int BIAS_SLOTS   = 256,
   parameter int FRAC_BITS    = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  dp_op_type   op,
   input  logic [23:0] lr,
   input  logic [23:0] b1,
   input  logic [23:0] b2,
   input  logic [23:0] eps,
   input  req_type     req_data,
   output dp_stat_type stat,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   localparam int WAW   = (WEIGHT_SLOTS > 1) ? $clog2(WEIGHT_SLOTS) : 1;
   localparam int BAW   = (BIAS_SLOTS > 1) ? $clog2(BIAS_SLOTS) : 1;
   localparam int MAXD  = (WEIGHT_SLOTS > BIAS_SLOTS) ? WEIGHT_SLOTS : BIAS_SLOTS;
   localparam int CLW   = $clog2(MAXD + 1);
   localparam int SQ_XW = 32 + FRAC_BITS;
   localparam int SQ_P  = (SQ_XW + 1) / 2;
   localparam int SQ_PW = 2 * SQ_P;
   localparam int SQ_CW = $clog2(SQ_P);
   localparam int EPW   = FRAC_BITS + 1;

   localparam logic signed [66:0] HALF_R = 67'sd1 <<< (REG_BITS - 1);
   localparam logic signed [66:0] HALF_F = 67'sd1 <<< (FRAC_BITS - 1);

   // moment stores, {first, second} per word
   logic [63:0] mem_w [0:WEIGHT_SLOTS-1];
   logic [63:0] mem_b [0:BIAS_SLOTS-1];
   logic [63:0] rdw_ff, rdb_ff;

   logic signed [31:0] w_ff, g_ff, m_ff, v_ff, t_ff, n_ff, q_ff, res_ff;
   logic signed [31:0] w_in, g_in, m_in, v_in, t_in, n_in, q_in, res_in;
   logic [9:0]         slot_ff, slot_in;
   logic               bias_ff, bias_in, starts_ff, starts_in, here_ff, here_in;
   logic               sat_ff, sat_in;
   logic signed [65:0] prod_ff, prod_in, acc_ff, acc_in;
   logic [24:0]        p1_ff, p1_in, p2_ff, p2_in;
   logic [32:0]        rem_ff, rem_in, dsr_ff, dsr_in;
   logic [31:0]        quo_ff, quo_in;
   logic               neg_ff, neg_in, ovf_ff, ovf_in, dz_ff, dz_in, nz_ff, nz_in;
   logic [4:0]         dcnt_ff, dcnt_in;
   logic [SQ_PW-1:0]   sx_ff, sx_in;
   logic [SQ_P+1:0]    srem_ff, srem_in;
   logic [SQ_P-1:0]    root_ff, root_in;
   logic [SQ_CW-1:0]   scnt_ff, scnt_in;
   logic [CLW-1:0]     clr_ff, clr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic signed [66:0] prx, dec_sum, rs_dec, rs_p, rs_g;
   logic [32:0]        sat_dec, sat_res, sat_gsq, sat_vadd;
   logic [EPW-1:0]     eps_s;
   logic [24:0]        d1, d2;
   logic [32:0]        den_r;
   logic [16:0]        slot_ext, req_slot_ext, clr_ext;
   logic [WAW-1:0]     wa_w, ra_w;
   logic [BAW-1:0]     wa_b, ra_b;
   logic               we_w, we_b, re;
   logic [33:0]        d_trial;
   logic               d_ge;
   logic [SQ_P+2:0]    s_rt, s_tr;
   logic               s_ge;
   logic               lr_bad;

   assign lr_bad = (lr == 24'd0) || (lr > LR_LIMIT);

   generate
      if (FRAC_BITS >= REG_BITS) begin : g_eps_up
         assign eps_s = EPW'(eps) << (FRAC_BITS - REG_BITS);
      end else begin : g_eps_dn
         assign eps_s = EPW'(({1'b0, eps} + (25'd1 << (REG_BITS - 1 - FRAC_BITS)))
                             >> (REG_BITS - FRAC_BITS));
      end
   endgenerate

   assign d1    = (p1_ff == REG_ONE) ? REG_ONE : (REG_ONE - p1_ff);
   assign d2    = (p2_ff == REG_ONE) ? REG_ONE : (REG_ONE - p2_ff);
   assign den_r = 33'(root_ff) + 33'(eps_s);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (op)
         OP_MUL_GLR: begin mul_a = 33'(g_ff); mul_b = 33'({1'b0, lr}); end
         OP_MUL_MB1: begin mul_a = 33'(m_ff); mul_b = 33'({1'b0, b1}); end
         OP_MUL_GB1: begin mul_a = 33'(g_ff); mul_b = 33'(REG_ONE - {1'b0, b1}); end
         OP_MUL_MLR: begin mul_a = 33'(m_ff); mul_b = 33'({1'b0, lr}); end
         OP_MUL_QLR: begin mul_a = 33'(q_ff); mul_b = 33'({1'b0, lr}); end
         OP_MUL_GG:  begin mul_a = 33'(g_ff); mul_b = 33'(g_ff); end
         OP_MUL_VB2: begin mul_a = 33'(v_ff); mul_b = 33'({1'b0, b2}); end
         OP_MUL_TB2: begin mul_a = 33'(t_ff); mul_b = 33'(REG_ONE - {1'b0, b2}); end
         OP_MUL_P1:  begin mul_a = 33'(p1_ff); mul_b = 33'({1'b0, b1}); end
         OP_MUL_P2:  begin mul_a = 33'(p2_ff); mul_b = 33'({1'b0, b2}); end
         default:    begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign prx     = 67'(prod_ff);
   assign dec_sum = 67'(acc_ff) + prx;
   assign rs_dec  = (dec_sum + HALF_R) >>> REG_BITS;
   assign rs_p    = (prx + HALF_R) >>> REG_BITS;
   assign rs_g    = (prx + HALF_F) >>> FRAC_BITS;
   assign sat_dec  = sat32(72'(rs_dec));
   assign sat_res  = sat32(72'(w_ff) - 72'(rs_p));
   assign sat_gsq  = sat32(72'(rs_g));
   assign sat_vadd = sat32(72'(v_ff) + 72'(t_ff));

   assign d_trial = {rem_ff, quo_ff[31]};
   assign d_ge    = d_trial >= {1'b0, dsr_ff};
   assign s_rt    = {srem_ff[SQ_P:0], sx_ff[SQ_PW-1 -: 2]};
   assign s_tr    = (SQ_P + 3)'({root_ff, 2'b01});
   assign s_ge    = s_rt >= s_tr;

   assign slot_ext     = {7'd0, slot_ff};
   assign req_slot_ext = {7'd0, req_data.slot};
   assign clr_ext      = 17'(clr_ff);
   assign ra_w = req_slot_ext[WAW-1:0];
   assign ra_b = req_slot_ext[BAW-1:0];
   assign wa_w = (op == OP_CLEAR) ? clr_ext[WAW-1:0] : slot_ext[WAW-1:0];
   assign wa_b = (op == OP_CLEAR) ? clr_ext[BAW-1:0] : slot_ext[BAW-1:0];
   assign re   = (op == OP_LOAD);
   assign we_w = ((op == OP_CLEAR) && (clr_ext < 17'(WEIGHT_SLOTS)))
              || ((op == OP_STORE) && here_ff && !bias_ff);
   assign we_b = ((op == OP_CLEAR) && (clr_ext < 17'(BIAS_SLOTS)))
              || ((op == OP_STORE) && here_ff && bias_ff);

   always_ff @(posedge clock) begin
      if (we_w) mem_w[wa_w] <= (op == OP_CLEAR) ? 64'd0 : {m_ff, v_ff};
      if (re) rdw_ff <= mem_w[ra_w];
   end

   always_ff @(posedge clock) begin
      if (we_b) mem_b[wa_b] <= (op == OP_CLEAR) ? 64'd0 : {m_ff, v_ff};
      if (re) rdb_ff <= mem_b[ra_b];
   end

   always_comb begin
      logic [31:0] num;
      logic [32:0] nsx, mag, dsr;
      logic [63:0] dvd;
      logic        use_frac;
      logic [31:0] sq_src;

      w_in = w_ff;  g_in = g_ff;  m_in = m_ff;  v_in = v_ff;  t_in = t_ff;
      n_in = n_ff;  q_in = q_ff;  res_in = res_ff;
      slot_in = slot_ff;  bias_in = bias_ff;  starts_in = starts_ff;  here_in = here_ff;
      sat_in = sat_ff;  prod_in = prod_ff;  acc_in = acc_ff;
      p1_in = p1_ff;  p2_in = p2_ff;
      rem_in = rem_ff;  dsr_in = dsr_ff;  quo_in = quo_ff;
      neg_in = neg_ff;  ovf_in = ovf_ff;  dz_in = dz_ff;  nz_in = nz_ff;  dcnt_in = dcnt_ff;
      sx_in = sx_ff;  srem_in = srem_ff;  root_in = root_ff;  scnt_in = scnt_ff;
      clr_in = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      num      = n_ff;
      dsr      = den_r;
      use_frac = 1'b1;
      case (op)
         OP_DIV_M: begin num = m_ff; dsr = 33'(d1); use_frac = 1'b0; end
         OP_DIV_V: begin num = v_ff; dsr = 33'(d2); use_frac = 1'b0; end
         default:  begin num = n_ff; dsr = den_r; use_frac = 1'b1; end
      endcase
      nsx = {num[31], num};
      mag = num[31] ? (33'd0 - nsx) : nsx;
      dvd = use_frac ? (64'(mag) << FRAC_BITS) : (64'(mag) << REG_BITS);
      sq_src = (op == OP_SQRT_Q) ? (q_ff[31] ? 32'd0 : q_ff) : v_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (op)
         OP_CLEAR: clr_in = clr_ff + CLW'(1);
         OP_LOAD: begin
            w_in      = req_data.weight_in;
            g_in      = req_data.gradient;
            slot_in   = req_data.slot;
            bias_in   = req_data.is_bias;
            starts_in = req_data.begins_call;
            here_in   = req_data.is_bias ? (req_slot_ext < 17'(BIAS_SLOTS))
                                         : (req_slot_ext < 17'(WEIGHT_SLOTS));
         end
         OP_FETCH: begin
            m_in   = here_ff ? (bias_ff ? rdb_ff[63:32] : rdw_ff[63:32]) : 32'sd0;
            v_in   = here_ff ? (bias_ff ? rdb_ff[31:0] : rdw_ff[31:0]) : 32'sd0;
            n_in   = g_ff;
            sat_in = 1'b0;
         end
         OP_MUL_GLR, OP_MUL_MB1, OP_MUL_GB1, OP_MUL_MLR, OP_MUL_QLR, OP_MUL_GG,
         OP_MUL_VB2, OP_MUL_TB2, OP_MUL_P1, OP_MUL_P2: begin
            prod_in = mul_p;
            acc_in  = prod_ff;
         end
         OP_POW1: p1_in = 25'(prod_ff >>> REG_BITS);
         OP_POW2: p2_in = 25'(prod_ff >>> REG_BITS);
         OP_GSQ: begin
            t_in   = sat_gsq[31:0];
            sat_in = sat_ff | sat_gsq[32];
         end
         OP_VADD: begin
            v_in   = sat_vadd[31:0];
            sat_in = sat_ff | sat_vadd[32];
         end
         OP_DEC_M: begin
            m_in   = sat_dec[31:0];
            sat_in = sat_ff | sat_dec[32];
         end
         OP_DEC_V: begin
            v_in   = sat_dec[31:0];
            sat_in = sat_ff | sat_dec[32];
         end
         OP_DIV_M, OP_DIV_V, OP_DIV_R: begin
            dsr_in  = dsr;
            rem_in  = {1'b0, dvd[63:32]};
            quo_in  = dvd[31:0];
            ovf_in  = {1'b0, dvd[63:32]} >= dsr;
            dz_in   = (dsr == 33'd0);
            nz_in   = (mag != 33'd0);
            neg_in  = num[31];
            dcnt_in = '0;
         end
         OP_DIV_STEP: begin
            rem_in  = d_ge ? 33'(d_trial - {1'b0, dsr_ff}) : d_trial[32:0];
            quo_in  = {quo_ff[30:0], d_ge};
            dcnt_in = dcnt_ff + 5'd1;
         end
         OP_DIV_END: begin
            if (dz_ff) begin
               sat_in = 1'b1;
               q_in   = !nz_ff ? 32'sd0 : (neg_ff ? DATA_MIN : DATA_MAX);
            end else if (ovf_ff) begin
               sat_in = 1'b1;
               q_in   = neg_ff ? DATA_MIN : DATA_MAX;
            end else if (neg_ff) begin
               if (quo_ff > 32'h80000000) begin
                  sat_in = 1'b1;
                  q_in   = DATA_MIN;
               end else begin
                  q_in = 32'd0 - quo_ff;
               end
            end else begin
               if (quo_ff > 32'h7FFFFFFF) begin
                  sat_in = 1'b1;
                  q_in   = DATA_MAX;
               end else begin
                  q_in = quo_ff;
               end
            end
         end
         OP_SET_N: n_in = q_ff;
         OP_SQRT_V, OP_SQRT_Q: begin
            sx_in   = SQ_PW'({sq_src, {FRAC_BITS{1'b0}}});
            srem_in = '0;
            root_in = '0;
            scnt_in = '0;
         end
         OP_SQRT_STEP: begin
            srem_in = s_ge ? (SQ_P + 2)'(s_rt - s_tr) : (SQ_P + 2)'(s_rt);
            root_in = {root_ff[SQ_P-2:0], s_ge};
            sx_in   = sx_ff << 2;
            scnt_in = scnt_ff + SQ_CW'(1);
         end
         OP_RES: begin
            res_in = sat_res[31:0];
            sat_in = sat_ff | sat_res[32];
         end
         OP_PASS: res_in = w_ff;
         OP_STORE, OP_EMIT: begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.weight_out = res_ff;
            rsp_data_in.status     = lr_bad ? STAT_LR_BAD : (sat_ff ? STAT_SAT : STAT_OK);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         p1_ff        <= REG_ONE;
         p2_ff        <= REG_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;  g_ff <= g_in;  m_ff <= m_in;  v_ff <= v_in;  t_ff <= t_in;
      n_ff <= n_in;  q_ff <= q_in;  res_ff <= res_in;
      slot_ff <= slot_in;  bias_ff <= bias_in;  starts_ff <= starts_in;  here_ff <= here_in;
      sat_ff <= sat_in;  prod_ff <= prod_in;  acc_ff <= acc_in;
      rem_ff <= rem_in;  dsr_ff <= dsr_in;  quo_ff <= quo_in;
      neg_ff <= neg_in;  ovf_ff <= ovf_in;  dz_ff <= dz_in;  nz_ff <= nz_in;
      dcnt_ff <= dcnt_in;
      sx_ff <= sx_in;  srem_ff <= srem_in;  root_ff <= root_in;  scnt_ff <= scnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign stat.lr_bad     = lr_bad;
   assign stat.starts     = starts_ff;
   assign stat.clear_done = (clr_ff == CLW'(MAXD - 1));
   assign stat.div_done   = (dcnt_ff == 5'(DIV_STEPS - 1));
   assign stat.sqrt_done  = (scnt_ff == SQ_CW'(SQ_P - 1));
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[dv/gou_update_checker.sv]
// Checker for the gradient optimizer update block: tracks CSR writes, predicts each
// updated weight and status, and compares them with the rsp channel. Uses gou_pkg.
`timescale 1ns / 1ps
module gou_update_checker import gou_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data,
   output int          fail_count,
   output int          pending
);

   localparam longint ONE   = 64'sd16777216;
   localparam longint D_MAX = 64'sd2147483647;
   localparam longint D_MIN = -64'sd2147483648;

   logic signed [31:0] m_wt [1024];
   logic signed [31:0] m_bs [256];
   logic signed [31:0] v_wt [1024];
   logic signed [31:0] v_bs [256];
   logic [24:0] b1_pow, b2_pow;

   logic [2:0]  cfg_mode;
   logic [23:0] cfg_lr, cfg_b1, cfg_b2, cfg_eps;

   rsp_type expected_updates[$];
   bit      clipped;

   function automatic longint clip(input longint x);
      if (x > D_MAX) begin
         clipped = 1'b1;
         return D_MAX;
      end
      if (x < D_MIN) begin
         clipped = 1'b1;
         return D_MIN;
      end
      return x;
   endfunction

   // arithmetic shift is a floor shift; bias by half for nearest, ties up
   function automatic longint rnd24(input longint x);
      return (x + (64'sd1 <<< 23)) >>> 24;
   endfunction

   function automatic longint int_sqrt(input longint unsigned v);
      longint unsigned res, bit_v;
      res   = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v >>= 2;
      while (bit_v != 0) begin
         if (v >= res + bit_v) begin
            v   = v - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res >>= 1;
         end
         bit_v >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint decay(input longint old, input longint beta, input longint x);
      return clip(rnd24(old * beta + (ONE - beta) * x));
   endfunction

   function automatic longint step_scaled(input longint w, input longint r, input longint v);
      longint den, q;
      den = int_sqrt(longint'(v) * ONE) + longint'(cfg_eps);
      if (den <= 0) begin
         clipped = 1'b1;
         q = (r > 0) ? D_MAX : ((r < 0) ? D_MIN : 0);
      end else begin
         q = clip((r * ONE) / den);
      end
      return clip(w - rnd24(q * longint'(cfg_lr)));
   endfunction

   function automatic rsp_type predict_weight(input req_type r);
      rsp_type o;
      longint w, g, m, v, gsq, d1, d2, mh, vh, res;
      bit here;
      w = longint'(r.weight_in);
      g = longint'(r.gradient);
      here = r.is_bias ? (r.slot < 256) : 1'b1;
      m = 0;
      v = 0;
      if (here) begin
         m = r.is_bias ? longint'(m_bs[r.slot[7:0]]) : longint'(m_wt[r.slot]);
         v = r.is_bias ? longint'(v_bs[r.slot[7:0]]) : longint'(v_wt[r.slot]);
      end
      res = w;
      clipped = 1'b0;
      o.status = STAT_OK;
      if (cfg_lr == 0 || cfg_lr > LR_LIMIT) begin
         o.status = STAT_LR_BAD;
      end else begin
         case (cfg_mode)
            MODE_SGD: begin
               res = clip(w - rnd24(g * longint'(cfg_lr)));
            end
            MODE_MOMENTUM: begin
               m = decay(m, longint'(cfg_b1), g);
               res = clip(w - rnd24(m * longint'(cfg_lr)));
            end
            MODE_ADAGRAD, MODE_RMSPROP: begin
               gsq = clip(rnd24(g * g));
               if (cfg_mode == MODE_ADAGRAD) v = clip(v + gsq);
               else v = decay(v, longint'(cfg_b2), gsq);
               res = step_scaled(w, g, v);
            end
            MODE_ADAM: begin
               if (r.begins_call) begin
                  b1_pow = 25'((longint'(b1_pow) * longint'(cfg_b1)) >>> 24);
                  b2_pow = 25'((longint'(b2_pow) * longint'(cfg_b2)) >>> 24);
               end
               gsq = clip(rnd24(g * g));
               m = decay(m, longint'(cfg_b1), g);
               v = decay(v, longint'(cfg_b2), gsq);
               d1 = ONE - longint'(b1_pow);
               d2 = ONE - longint'(b2_pow);
               if (d1 <= 0) d1 = ONE;
               if (d2 <= 0) d2 = ONE;
               mh = clip((m * ONE) / d1);
               vh = clip((v * ONE) / d2);
               if (vh < 0) vh = 0;
               res = step_scaled(w, mh, vh);
            end
            default: ;
         endcase
         if (here && cfg_mode inside {MODE_MOMENTUM, MODE_ADAM}) begin
            if (r.is_bias) m_bs[r.slot[7:0]] = 32'(m);
            else m_wt[r.slot] = 32'(m);
         end
         if (here && cfg_mode inside {MODE_ADAGRAD, MODE_RMSPROP, MODE_ADAM}) begin
            if (r.is_bias) v_bs[r.slot[7:0]] = 32'(v);
            else v_wt[r.slot] = 32'(v);
         end
         if (clipped) o.status = STAT_SAT;
      end
      o.weight_out = 32'(res);
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         foreach (m_wt[i]) begin
            m_wt[i] = 0;
            v_wt[i] = 0;
         end
         foreach (m_bs[i]) begin
            m_bs[i] = 0;
            v_bs[i] = 0;
         end
         b1_pow     = REG_ONE;
         b2_pow     = REG_ONE;
         cfg_mode   = MODE_SGD;
         cfg_lr     = LR_RESET;
         cfg_b1     = B1_RESET;
         cfg_b2     = B2_RESET;
         cfg_eps    = EPS_RESET;
         fail_count = 0;
         expected_updates.delete();
      end else begin
         // the result leaving now belongs to an earlier item, so check first
         if (rsp_valid && rsp_ready) begin
            if (expected_updates.size() == 0) begin
               $error("unexpected result transfer: weight_out %0d status %0d",
                      rsp_data.weight_out, rsp_data.status);
               fail_count++;
            end else begin
               exp_rsp = expected_updates.pop_front();
               if (rsp_data.weight_out !== exp_rsp.weight_out) begin
                  $error("weight_out expected %0d got %0d",
                         exp_rsp.weight_out, rsp_data.weight_out);
                  fail_count++;
               end
               if (rsp_data.status !== exp_rsp.status) begin
                  $error("status expected %0d got %0d", exp_rsp.status, rsp_data.status);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE: cfg_mode = csr_data[2:0];
               CSR_LR:   cfg_lr   = csr_data;
               CSR_B1:   cfg_b1   = csr_data;
               CSR_B2:   cfg_b2   = csr_data;
               CSR_EPS:  cfg_eps  = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) expected_updates.push_back(predict_weight(req_data));
      end
      pending = expected_updates.size();
   end

endmodule

[dv/tb.sv]
// Testbench top for gradient_optimizer_update: clock, reset, CSR phases and item
// traffic with random gaps and stalls. Depends on gou_pkg and gou_update_checker.
`timescale 1ns / 1ps
module tb import gou_pkg::*; ();

   logic        clock;
   logic        reset;
   logic        req_valid, req_ready;
   req_type     req_data;
   logic        rsp_valid, rsp_ready;
   rsp_type     rsp_data;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [23:0] csr_data;
   int          fail_count, pending;
   bit          no_gaps;

   gradient_optimizer_update dut (.*);

   gou_update_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb NOT OK");
      $finish;
   end

   // result side stalls
   initial begin
      int n;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         n = no_gaps ? 0 : $urandom_range(0, 6);
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_csr(input logic [2:0] idx, input logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(input req_type item);
      int n;
      n = no_gaps ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain_and_set(input logic [2:0] mode, input logic [23:0] lr,
                                input logic [23:0] b1, input logic [23:0] b2,
                                input logic [23:0] eps);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      write_csr(CSR_MODE, {21'd0, mode});
      write_csr(CSR_LR, lr);
      write_csr(CSR_B1, b1);
      write_csr(CSR_B2, b2);
      write_csr(CSR_EPS, eps);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [31:0] pick_value(input bit wide);
      logic signed [31:0] x;
      x = $urandom;
      case ($urandom_range(0, 9))
         0: x = 32'sh7FFFFFFF;
         1: x = 32'sh80000000;
         2: x = $urandom_range(0, 3) - 1;
         3, 4: ;
         default: if (!wide) x = x >>> $urandom_range(4, 10);
      endcase
      return x;
   endfunction

   // calls of consecutive slots, mostly in one bank with a call start first
   task automatic run_calls(input int count);
      req_type it;
      int len, start;
      bit bank;
      while (count > 0) begin
         len   = $urandom_range(1, 12);
         bank  = 1'($urandom_range(0, 1));
         start = (bank && $urandom_range(0, 7) != 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 1023);
         for (int i = 0; i < len && count > 0; i++) begin
            it.weight_in   = pick_value(1'b1);
            it.gradient    = pick_value(1'b0);
            it.slot        = 10'(start + i);
            it.is_bias     = ($urandom_range(0, 9) == 0) ? ~bank : bank;
            it.begins_call = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1))
                                                         : (i == 0);
            send_item(it);
            count--;
         end
         if ($urandom_range(0, 15) == 0) no_gaps = ~no_gaps;
      end
   endtask

   initial begin
      req_type it;
      logic [23:0] lr_pick;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_MODE;
      csr_data  = '0;
      no_gaps   = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes in reset mode
      it = '{32'sh7FFFFFFF, 32'sh80000000, 10'd0, 1'b0, 1'b1};
      send_item(it);
      it = '{32'sh80000000, 32'sh7FFFFFFF, 10'd1023, 1'b1, 1'b0};
      send_item(it);
      it = '{32'sd0, 32'sd0, 10'd255, 1'b1, 1'b1};
      send_item(it);

      // Adam without and then with a call start, betas at the top of their range
      drain_and_set(MODE_ADAM, 24'd1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      it = '{32'sd16777216, 32'sd1677721, 10'd5, 1'b0, 1'b0};
      send_item(it);
      it = '{-32'sd16777216, -32'sd99999, 10'd300, 1'b1, 1'b0};
      send_item(it);
      it = '{32'sd123, 32'sh7FFFFFFF, 10'd6, 1'b0, 1'b1};
      send_item(it);

      // zero denominator: fresh slots, epsilon zero
      drain_and_set(MODE_ADAGRAD, LR_LIMIT, 24'd0, 24'd0, 24'd0);
      it = '{32'sd1000, 32'sd0, 10'd700, 1'b0, 1'b0};
      send_item(it);
      it = '{32'sd1000, 32'sd1, 10'd701, 1'b0, 1'b0};
      send_item(it);
      it = '{32'sd1000, -32'sd1, 10'd100, 1'b1, 1'b0};
      send_item(it);

      // invalid learning rates: zero, just above the limit and the maximum
      drain_and_set(MODE_SGD, 24'd0, B1_RESET, B2_RESET, EPS_RESET);
      it = '{32'sd77, 32'sd5, 10'd3, 1'b0, 1'b1};
      send_item(it);
      drain_and_set(MODE_ADAM, LR_LIMIT + 24'd1, B1_RESET, B2_RESET, EPS_RESET);
      it = '{32'sd77, 32'sd5, 10'd3, 1'b0, 1'b1};
      send_item(it);
      drain_and_set(MODE_ADAM, 24'hFFFFFF, B1_RESET, B2_RESET, EPS_RESET);
      send_item(it);

      // unknown modes
      drain_and_set(3'd5, LR_RESET, B1_RESET, B2_RESET, EPS_RESET);
      send_item(it);
      drain_and_set(3'd7, LR_RESET, B1_RESET, B2_RESET, EPS_RESET);
      send_item(it);

      // random phases across every mode, with random register settings
      for (int ph = 0; ph < 16; ph++) begin
         case ($urandom_range(0, 3))
            0: lr_pick = LR_LIMIT;
            1: lr_pick = 24'd1;
            2: lr_pick = 24'($urandom_range(1, LR_LIMIT));
            default: lr_pick = $urandom_range(0, 3) == 0 ? 24'($urandom) : LR_RESET;
         endcase
         drain_and_set((ph < 14) ? 3'(ph % 5) : 3'($urandom_range(5, 7)), lr_pick,
                       ($urandom_range(0, 3) == 0) ? 24'($urandom) : B1_RESET,
                       ($urandom_range(0, 3) == 0) ? 24'($urandom) : B2_RESET,
                       ($urandom_range(0, 2) == 0) ? 24'($urandom_range(0, 4095))
                                                   : EPS_RESET);
         run_calls(ph < 14 ? 135 : 40);
      end
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
